[rtl/cotf_pkg.sv]
// shared types and constants of the clock offset tracking filter
`default_nettype none

package cotf_pkg;

   typedef enum logic [4:0] {
      S_IDLE,
      S_OBS,
      S_SCREEN,
      S_DECIDE,
      S_DIV,
      S_BLA0,
      S_BLA1,
      S_BLB0,
      S_BLB1,
      S_GAIN,
      S_FIRST,
      S_PRED,
      S_DIFF,
      S_ERR,
      S_MULD,
      S_DELTA,
      S_UPD,
      S_MULS,
      S_SKEW,
      S_ACCEPT,
      S_FINISH
   } state_type;

   localparam int MAC_W = 84;

   typedef struct packed {
      logic       en;
      logic       clear;
      logic [1:0] lane;
   } mac_ctl_type;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_RTT_HIGH = 2'd1;
   localparam logic [1:0] ST_OUTLIER  = 2'd2;
   localparam logic [1:0] ST_RESET    = 2'd3;

   localparam logic [3:0] CSR_ALPHA_START   = 4'd0;
   localparam logic [3:0] CSR_BETA_START    = 4'd1;
   localparam logic [3:0] CSR_ALPHA_END     = 4'd2;
   localparam logic [3:0] CSR_BETA_END      = 4'd3;
   localparam logic [3:0] CSR_SETTLE        = 4'd4;
   localparam logic [3:0] CSR_RTT_LIMIT     = 4'd5;
   localparam logic [3:0] CSR_DEV_LIMIT     = 4'd6;
   localparam logic [3:0] CSR_OUTLIER_LIMIT = 4'd7;

   localparam logic [35:0] NS_PER_MS   = 36'd1000000;
   localparam logic [46:0] ERR_INT_LIM = 47'h4000_0000_0000;
   localparam logic [63:0] INT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_MIN     = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

[rtl/cotf_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module cotf_div #(
   parameter int DW = 23
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [15:0]   divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);
   import cotf_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [15:0]   rem_ff;
   logic [DW-1:0] quo_ff;
   logic [16:0]   rem_sh;
   logic          fits;
   logic [16:0]   rem_in;

   assign rem_sh = {rem_ff, quo_ff[DW-1]};
   assign fits   = rem_sh >= {1'b0, divisor};
   assign rem_in = fits ? rem_sh - {1'b0, divisor} : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in[15:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/cotf_mac.sv]
// shared 18x18 multiplier with shifting accumulator
`default_nettype none

module cotf_mac (
   input  wire logic                         clock,
   input  wire cotf_pkg::mac_ctl_type        ctl,
   input  wire logic signed [17:0]           op_a,
   input  wire logic signed [17:0]           op_b,
   output logic signed [cotf_pkg::MAC_W-1:0] acc
);
   import cotf_pkg::*;

   logic signed [35:0]      prod;
   logic signed [MAC_W-1:0] term;
   logic signed [MAC_W-1:0] acc_ff;
   logic signed [MAC_W-1:0] acc_in;

   assign prod = op_a * op_b;
   assign term = $signed({{(MAC_W - 36){prod[35]}}, prod}) <<< {ctl.lane, 4'b0000};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.en) begin
         acc_in = (ctl.clear ? '0 : acc_ff) + term;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

[rtl/clock_offset_tracking_filter.sv]
// clock offset tracking filter top level: sequencer, filter state and ports
`default_nettype none

// Takes one sync message per request word and returns one response word for it. A zero
// remote stamp yields a reply and a negative one is ignored; a rejected sample and the
// first accepted sample skip the gain arithmetic. Before convergence a later accepted
// sample waits on the divider, which yields one schedule index bit per cycle, and every
// later accepted sample uses the single 18x18 multiplier that does the gain blend and
// each 64-bit gain product in four 16-bit slices. Requests are taken only while the
// sequencer is idle, in the cycle after a response is loaded; a finished response waits
// in its own register, so the next request may enter while it is still pending.
module clock_offset_tracking_filter #(
   parameter int GAIN_TABLE_DEPTH   = 64,
   parameter int SLOW_RTT_RUN_LIMIT = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // remote_stamp, echo_stamp, arrival_time
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // reply_remote_stamp, reply_echo_stamp, observed_offset, estimated_offset,
   // round_trip_ns, sample_status, rtt_warning, shared_offset, converged, pad
   output logic [391:0]      rsp_tdata,
   // reply_valid, observation_valid
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [3:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   import cotf_pkg::*;

   localparam int IW = $clog2(GAIN_TABLE_DEPTH);
   localparam int DW = 16 + $clog2(GAIN_TABLE_DEPTH + 1);

   typedef logic [16:0] ptab_type [GAIN_TABLE_DEPTH];

   // elaboration-time shift-subtract quotient
   function automatic logic [63:0] const_quot(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic ptab_type build_ptab();
      ptab_type    t;
      logic [63:0] rem;
      logic [63:0] y;
      logic [63:0] sum;
      logic [63:0] term;
      for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
         rem = 64'(GAIN_TABLE_DEPTH - i);
         if (64'(i) >= 64'd24 * rem) begin
            t[i] = 17'd65536;
         end else begin
            y    = const_quot(64'(i) << 31, rem << 5);
            sum  = 64'd1 << 31;
            term = 64'd1 << 31;
            for (int k = 1; k <= 20; k++) begin
               term = const_quot((term * y) >> 31, 64'(k));
               if (k[0]) sum = sum - term;
               else sum = sum + term;
            end
            for (int k = 0; k < 4; k++) begin
               sum = (sum * sum + (64'd1 << 30)) >> 31;
            end
            t[i] = 17'(64'd65536 - ((sum + 64'd16384) >> 15));
         end
      end
      return t;
   endfunction

   localparam ptab_type P_TAB = build_ptab();

   function automatic logic [79:0] add_q16(input logic [79:0] base, input logic [63:0] v);
      logic [80:0] s;
      logic [63:0] r;
      logic [15:0] f;
      s = {base[79], base} + {{17{v[63]}}, v};
      if (s[80] != s[79]) begin
         r = s[80] ? INT_MIN : INT_MAX;
         f = '0;
      end else begin
         r = s[79:16];
         f = s[15:0];
      end
      if (r == INT_MAX) f = 16'hFFFF;
      if (r == INT_MIN) f = 16'h0000;
      return {r, f};
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? INT_MIN : INT_MAX;
      return s[63:0];
   endfunction

   // state machine
   state_type state_ff, state_in;

   // configuration
   logic [15:0] alpha_start_ff, beta_start_ff, alpha_end_ff, beta_end_ff, settle_ff;
   logic [35:0] rtt_lim_ff, dev_lim_ff;
   logic [7:0]  outlier_lim_ff;

   // filter state
   logic [63:0] offset_ff;
   logic [15:0] frac_ff;
   logic [63:0] skew_ff;
   logic [15:0] count_ff;
   logic [7:0]  outlier_ff;
   logic [7:0]  slow_ff;

   // per word
   logic [63:0] remote_ff, echo_ff, arrival_ff;
   logic [63:0] obs_ff, rtt_ff, dev_ff;
   logic        rtt_slow_ff;
   logic        rv_ff, ov_ff, warn_ff;
   logic [1:0]  status_ff;
   logic [15:0] alpha_ff, beta_ff;
   logic [16:0] p_ff;
   logic [63:0] pi_ff;
   logic [15:0] pf_ff;
   logic [46:0] du_ff;
   logic        ge_ff;
   logic [63:0] err_ff, delta_ff;
   logic [1:0]  lane_ff;

   // response
   logic         rsp_valid_ff;
   logic [391:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;

   // control
   logic                    req_acc, csr_acc, out_free, out_load, div_start, div_done;
   logic [DW-1:0]           div_q;
   mac_ctl_type             mac_ctl;
   logic signed [17:0]      mac_a, mac_b;
   logic signed [MAC_W-1:0] mac_acc;
   logic                    c0, dev_out, first;
   logic [63:0]             est;
   logic [63:0]             s_sum, s_neg, half;
   logic [63:0]             obs_m_pi;
   logic [63:0]             pi_m_obs;
   logic [63:0]             mag;
   logic [79:0]             pred_q, upd_q;
   logic [8:0]              slow_n, outlier_n;
   logic [63:0]             chunk_src;
   logic [17:0]             chunk;
   logic [32:0]             blend_r;

   assign req_acc  = req_tvalid && req_tready;
   assign csr_acc  = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign c0       = count_ff >= settle_ff;
   assign dev_out  = dev_ff > 64'(dev_lim_ff);
   assign first    = count_ff == 16'd0;
   assign est      = ($signed(offset_ff) < 0 && frac_ff != 16'd0) ? offset_ff + 64'd1
                                                                  : offset_ff;
   assign s_sum    = echo_ff + arrival_ff - {remote_ff[62:0], 1'b0};
   assign s_neg    = 64'd0 - s_sum;
   assign half     = s_sum[63] ? 64'd0 - (s_neg >> 1) : (s_sum >> 1);
   assign obs_m_pi = obs_ff - pi_ff;
   assign pi_m_obs = pi_ff - obs_ff;
   assign mag      = {1'b0, du_ff, 16'd0};
   assign pred_q   = add_q16({pi_ff, pf_ff}, skew_ff);
   assign upd_q    = add_q16({pi_ff, pf_ff}, delta_ff);
   assign slow_n   = {1'b0, slow_ff} + 9'd1;
   assign outlier_n = {1'b0, outlier_ff} + 9'd1;
   assign blend_r  = mac_acc[32:0] + 33'd32768;

   cotf_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DW'(count_ff) * DW'(GAIN_TABLE_DEPTH)),
      .divisor  (settle_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   cotf_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_acc) state_in = S_OBS;
         S_OBS:    state_in = (remote_ff == 64'd0 || remote_ff[63]) ? S_FINISH : S_SCREEN;
         S_SCREEN: state_in = S_DECIDE;
         S_DECIDE: begin
            if (rtt_slow_ff || (c0 && dev_out)) state_in = S_FINISH;
            else if (first) state_in = S_FIRST;
            else if (c0) state_in = S_PRED;
            else state_in = S_DIV;
         end
         S_DIV:    if (div_done) state_in = S_BLA0;
         S_BLA0:   state_in = S_BLA1;
         S_BLA1:   state_in = S_BLB0;
         S_BLB0:   state_in = S_BLB1;
         S_BLB1:   state_in = S_GAIN;
         S_GAIN:   state_in = S_PRED;
         S_FIRST:  state_in = S_ACCEPT;
         S_PRED:   state_in = S_DIFF;
         S_DIFF:   state_in = S_ERR;
         S_ERR:    state_in = S_MULD;
         S_MULD:   if (lane_ff == 2'd3) state_in = S_DELTA;
         S_DELTA:  state_in = S_UPD;
         S_UPD:    state_in = S_MULS;
         S_MULS:   if (lane_ff == 2'd3) state_in = S_SKEW;
         S_SKEW:   state_in = S_ACCEPT;
         S_ACCEPT: state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      mac_ctl    = '{en: 1'b0, clear: 1'b0, lane: 2'd0};
      mac_a      = '0;
      mac_b      = '0;
      chunk_src  = (state_ff == S_MULS) ? delta_ff : err_ff;
      chunk      = (lane_ff == 2'd3) ? {{2{chunk_src[63]}}, chunk_src[63:48]}
                                     : {2'b00, chunk_src[{lane_ff, 4'b0000} +: 16]};
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
         end
         S_DECIDE: div_start = !rtt_slow_ff && !c0 && !first;
         S_BLA0: begin
            mac_ctl = '{en: 1'b1, clear: 1'b1, lane: 2'd0};
            mac_a   = $signed({1'b0, p_ff});
            mac_b   = $signed({2'b00, alpha_end_ff});
         end
         S_BLA1: begin
            mac_ctl = '{en: 1'b1, clear: 1'b0, lane: 2'd0};
            mac_a   = $signed({1'b0, 17'd65536 - p_ff});
            mac_b   = $signed({2'b00, alpha_start_ff});
         end
         S_BLB0: begin
            mac_ctl = '{en: 1'b1, clear: 1'b1, lane: 2'd0};
            mac_a   = $signed({1'b0, p_ff});
            mac_b   = $signed({2'b00, beta_end_ff});
         end
         S_BLB1: begin
            mac_ctl = '{en: 1'b1, clear: 1'b0, lane: 2'd0};
            mac_a   = $signed({1'b0, 17'd65536 - p_ff});
            mac_b   = $signed({2'b00, beta_start_ff});
         end
         S_MULD: begin
            mac_ctl = '{en: 1'b1, clear: (lane_ff == 2'd0), lane: lane_ff};
            mac_a   = $signed(chunk);
            mac_b   = $signed({2'b00, alpha_ff});
         end
         S_MULS: begin
            mac_ctl = '{en: 1'b1, clear: (lane_ff == 2'd0), lane: lane_ff};
            mac_a   = $signed(chunk);
            mac_b   = $signed({2'b00, beta_ff});
         end
         S_FINISH: out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         alpha_start_ff <= 16'd3277;
         beta_start_ff  <= 16'd3277;
         alpha_end_ff   <= 16'd197;
         beta_end_ff    <= 16'd197;
         settle_ff      <= 16'd500;
         rtt_lim_ff     <= 36'd10 * NS_PER_MS;
         dev_lim_ff     <= 36'd10 * NS_PER_MS;
         outlier_lim_ff <= 8'd10;
         offset_ff      <= '0;
         frac_ff        <= '0;
         skew_ff        <= '0;
         count_ff       <= '0;
         outlier_ff     <= '0;
         slow_ff        <= '0;
         rv_ff          <= 1'b0;
         ov_ff          <= 1'b0;
         warn_ff        <= 1'b0;
         status_ff      <= ST_ACCEPTED;
         lane_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_acc) begin
            unique case (csr_index)
               CSR_ALPHA_START:   alpha_start_ff <= csr_data;
               CSR_BETA_START:    beta_start_ff  <= csr_data;
               CSR_ALPHA_END:     alpha_end_ff   <= csr_data;
               CSR_BETA_END:      beta_end_ff    <= csr_data;
               CSR_SETTLE:        settle_ff      <= csr_data;
               CSR_RTT_LIMIT:     rtt_lim_ff     <= 36'(csr_data) * NS_PER_MS;
               CSR_DEV_LIMIT:     dev_lim_ff     <= 36'(csr_data) * NS_PER_MS;
               CSR_OUTLIER_LIMIT: outlier_lim_ff <= csr_data[7:0];
               default: ;
            endcase
            if (csr_index == CSR_ALPHA_START || csr_index == CSR_BETA_START ||
                csr_index == CSR_ALPHA_END || csr_index == CSR_BETA_END) begin
               offset_ff  <= '0;
               frac_ff    <= '0;
               skew_ff    <= '0;
               count_ff   <= '0;
               outlier_ff <= '0;
               slow_ff    <= '0;
            end
         end
         if (req_acc) begin
            rv_ff     <= 1'b0;
            ov_ff     <= 1'b0;
            warn_ff   <= 1'b0;
            status_ff <= ST_ACCEPTED;
         end
         if (state_ff == S_MULD || state_ff == S_MULS) lane_ff <= lane_ff + 2'd1;
         unique case (state_ff)
            S_OBS: begin
               rv_ff <= remote_ff == 64'd0;
               ov_ff <= remote_ff != 64'd0 && !remote_ff[63];
            end
            S_DECIDE: begin
               if (rtt_slow_ff) begin
                  status_ff <= ST_RTT_HIGH;
                  if (slow_n > 9'(SLOW_RTT_RUN_LIMIT)) begin
                     warn_ff <= 1'b1;
                     slow_ff <= '0;
                  end else begin
                     slow_ff <= slow_n[7:0];
                  end
               end else if (c0 && dev_out) begin
                  if (outlier_n > {1'b0, outlier_lim_ff}) begin
                     status_ff  <= ST_RESET;
                     offset_ff  <= '0;
                     frac_ff    <= '0;
                     skew_ff    <= '0;
                     count_ff   <= '0;
                     outlier_ff <= '0;
                     slow_ff    <= '0;
                  end else begin
                     status_ff  <= ST_OUTLIER;
                     outlier_ff <= outlier_n[7:0];
                  end
               end
            end
            S_FIRST: begin
               offset_ff <= obs_ff;
               frac_ff   <= '0;
            end
            S_UPD: begin
               offset_ff <= upd_q[79:16];
               frac_ff   <= upd_q[15:0];
            end
            S_SKEW: skew_ff <= sat_add(skew_ff, mac_acc[79:16]);
            S_ACCEPT: begin
               if (count_ff != 16'hFFFF) count_ff <= count_ff + 16'd1;
               outlier_ff <= '0;
               slow_ff    <= '0;
               status_ff  <= ST_ACCEPTED;
            end
            default: ;
         endcase
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         remote_ff  <= req_tdata[63:0];
         echo_ff    <= req_tdata[127:64];
         arrival_ff <= req_tdata[191:128];
      end
      unique case (state_ff)
         S_OBS: begin
            obs_ff <= half;
            rtt_ff <= arrival_ff - echo_ff;
         end
         S_SCREEN: begin
            rtt_slow_ff <= !(rtt_ff < 64'(rtt_lim_ff));
            dev_ff      <= ($signed(est) >= $signed(obs_ff)) ? est - obs_ff : obs_ff - est;
         end
         S_DECIDE: begin
            alpha_ff <= alpha_end_ff;
            beta_ff  <= beta_end_ff;
            pi_ff    <= offset_ff;
            pf_ff    <= frac_ff;
         end
         S_DIV: if (div_done) p_ff <= P_TAB[div_q[IW-1:0]];
         S_BLB0: alpha_ff <= blend_r[31:16];
         S_GAIN: beta_ff <= blend_r[31:16];
         S_PRED: begin
            pi_ff <= pred_q[79:16];
            pf_ff <= pred_q[15:0];
         end
         S_DIFF: begin
            ge_ff <= $signed(obs_ff) >= $signed(pi_ff);
            if ($signed(obs_ff) >= $signed(pi_ff)) begin
               du_ff <= (obs_m_pi > 64'(ERR_INT_LIM)) ? ERR_INT_LIM : obs_m_pi[46:0];
            end else begin
               du_ff <= (pi_m_obs > 64'(ERR_INT_LIM)) ? ERR_INT_LIM : pi_m_obs[46:0];
            end
         end
         S_ERR: err_ff <= ge_ff ? mag - 64'(pf_ff) : 64'd0 - mag - 64'(pf_ff);
         S_DELTA: delta_ff <= mac_acc[79:16];
         default: ;
      endcase
      if (out_load) begin
         rsp_user_ff <= {ov_ff, rv_ff};
         rsp_data_ff <= {4'b0000,
                         c0,
                         c0 ? est : 64'd0,
                         warn_ff,
                         ov_ff ? status_ff : ST_ACCEPTED,
                         ov_ff ? rtt_ff : 64'd0,
                         est,
                         ov_ff ? obs_ff : 64'd0,
                         rv_ff ? echo_ff : 64'd0,
                         rv_ff ? arrival_ff : 64'd0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_shared_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[387]) |-> (rsp_tdata[386:323] == 64'd0))
      else $error("shared offset published before convergence");

   a_div_in_place: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside its wait state");

   a_slow_run_bound: assert property (@(posedge clock) disable iff (reset)
      slow_ff <= 8'(SLOW_RTT_RUN_LIMIT))
      else $error("slow round trip run passed its limit");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (state_ff == S_IDLE))
      else $error("response loaded without returning idle");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for the clock offset tracking filter
`timescale 1ns / 1ps

module tb_top;
   import cotf_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int SLOW_RUN_MAX = 10;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS = 236;

   typedef struct {
      bit        rv;
      bit        ov;
      bit [63:0] rr;
      bit [63:0] re;
      bit [63:0] obs;
      bit [63:0] est;
      bit [63:0] rtt;
      bit [1:0]  st;
      bit        warn;
      bit [63:0] shared;
      bit        conv;
   } sync_result_type;

   typedef struct {
      bit [63:0] remote;
      bit [63:0] echo;
      bit [63:0] arrival;
      bit        typed;
      bit        rv;
   } sync_row_type;

   logic          clock, reset;
   logic          req_tvalid, req_tready;
   logic [191:0]  req_tdata;
   logic          rsp_tvalid, rsp_tready;
   logic [391:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_valid, csr_ready;
   logic [3:0]    csr_index;
   logic [15:0]   csr_data;

   clock_offset_tracking_filter #(
      .GAIN_TABLE_DEPTH   (TABLE_DEPTH),
      .SLOW_RTT_RUN_LIMIT (SLOW_RUN_MAX)
   ) u_top (.*);

   // register copies
   bit [15:0] alpha_start, beta_start, alpha_end, beta_end;
   bit [15:0] settle_samples, rtt_limit_ms, dev_limit_ms;
   bit [7:0]  outlier_limit;
   // filter state copies
   longint       off_int, skew;
   int unsigned  off_frac, accepted, outlier_run, slow_run;

   sync_result_type pending_results[$];
   int  errors;
   bit  quiet;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void clear_filter();
      off_int = 0; off_frac = 0; skew = 0;
      accepted = 0; outlier_run = 0; slow_run = 0;
   endfunction

   function automatic void write_reg(bit [3:0] idx, bit [15:0] val);
      case (idx)
         CSR_ALPHA_START: begin alpha_start = val; clear_filter(); end
         CSR_BETA_START: begin beta_start = val; clear_filter(); end
         CSR_ALPHA_END: begin alpha_end = val; clear_filter(); end
         CSR_BETA_END: begin beta_end = val; clear_filter(); end
         CSR_SETTLE: settle_samples = val;
         CSR_RTT_LIMIT: rtt_limit_ms = val;
         CSR_DEV_LIMIT: dev_limit_ms = val;
         CSR_OUTLIER_LIMIT: outlier_limit = val[7:0];
         default: ;
      endcase
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? INT_MIN : INT_MAX;
      return s[63:0];
   endfunction

   function automatic void add_frac(inout longint ip, inout int unsigned fp, input longint v);
      longint       vi, r;
      int unsigned  f;
      vi = v >>> 16;
      f = fp + {16'b0, v[15:0]};
      r = sat_sum(ip, vi + longint'(f >> 16));
      f = f & 32'hFFFF;
      if (r == INT_MAX) f = 32'hFFFF;
      if (r == INT_MIN) f = 0;
      ip = r;
      fp = f;
   endfunction

   function automatic longint gain_mul(int unsigned g, longint v);
      longint            hi;
      longint unsigned   lo;
      hi = v >>> 16;
      lo = {48'b0, v[15:0]};
      return hi * longint'(g) + longint'((lo * g) >> 16);
   endfunction

   function automatic longint est_trunc();
      if (off_int < 0 && off_frac != 0) return off_int + 1;
      return off_int;
   endfunction

   function automatic bit [63:0] abs_gap(longint a, longint b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic int unsigned sched_weight(int unsigned i);
      longint unsigned rem, y, sum, term;
      rem = TABLE_DEPTH - i;
      if (64'(i) >= 24 * rem) return 65536;
      y = (64'(i) << 31) / (32 * rem);
      sum = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * y) >> 31) / k;
         if (k % 2 == 1) sum = sum - term; else sum = sum + term;
      end
      for (int k = 0; k < 4; k++) sum = (sum * sum + (64'd1 << 30)) >> 31;
      return 65536 - int'((sum + (1 << 14)) >> 15);
   endfunction

   function automatic int unsigned blend_gain(int unsigned p, bit [15:0] s, bit [15:0] e);
      longint unsigned acc;
      acc = 64'(p) * e + 64'(65536 - p) * s + 32768;
      return int'(acc >> 16);
   endfunction

   function automatic sync_result_type predict_sync(bit [63:0] remote, echo, arrival);
      sync_result_type r;
      bit [63:0]    s, half, rtt, du;
      longint       obs, pi, err, delta;
      int unsigned  pf, n, a, b, p, idx;
      bit           c0;
      r = '{default: 0};
      if (remote == 0) begin
         r.rv = 1; r.rr = arrival; r.re = echo;
      end else if (!remote[63]) begin
         s = echo + arrival - (remote << 1);
         half = s[63] ? -((-s) >> 1) : (s >> 1);
         obs = half;
         rtt = arrival - echo;
         r.ov = 1; r.obs = half; r.rtt = rtt;
         if (rtt < 64'(rtt_limit_ms) * 64'(NS_PER_MS)) begin
            c0 = accepted >= settle_samples;
            if (c0 && abs_gap(est_trunc(), obs) > 64'(dev_limit_ms) * 64'(NS_PER_MS)) begin
               n = outlier_run + 1;
               if (n > outlier_limit) begin
                  clear_filter(); r.st = ST_RESET;
               end else begin
                  outlier_run = n; r.st = ST_OUTLIER;
               end
            end else begin
               if (c0) begin
                  a = alpha_end; b = beta_end;
               end else begin
                  idx = (accepted * TABLE_DEPTH) / settle_samples;
                  p = sched_weight(idx);
                  a = blend_gain(p, alpha_start, alpha_end);
                  b = blend_gain(p, beta_start, beta_end);
               end
               if (accepted == 0) begin
                  off_int = obs; off_frac = 0;
               end else begin
                  pi = off_int; pf = off_frac;
                  add_frac(pi, pf, skew);
                  du = abs_gap(obs, pi);
                  if (du > 64'(ERR_INT_LIM)) du = 64'(ERR_INT_LIM);
                  if (obs >= pi) err = longint'(du << 16) - longint'(pf);
                  else err = -longint'(du << 16) - longint'(pf);
                  delta = gain_mul(a, err);
                  add_frac(pi, pf, delta);
                  off_int = pi; off_frac = pf;
                  skew = sat_sum(skew, gain_mul(b, delta));
               end
               if (accepted < 65535) accepted++;
               outlier_run = 0; slow_run = 0;
               r.st = ST_ACCEPTED;
            end
         end else begin
            n = slow_run + 1;
            r.st = ST_RTT_HIGH;
            if (n > SLOW_RUN_MAX) begin
               r.warn = 1; slow_run = 0;
            end else slow_run = n & 8'hFF;
         end
      end
      r.est = est_trunc();
      r.conv = accepted >= settle_samples;
      r.shared = r.conv ? r.est : 64'd0;
      return r;
   endfunction

   task automatic send_sync(bit [63:0] remote, echo, arrival, bit typed = 0, bit rv = 0);
      sync_result_type r;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 6) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {arrival, echo, remote};
      do @(posedge clock); while (!req_tready);
      r = predict_sync(remote, echo, arrival);
      if (typed) begin
         r = '{default: 0};
         r.rv = rv;
         if (rv) begin r.rr = arrival; r.re = echo; end
      end
      pending_results.push_back(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(bit [3:0] idx, bit [15:0] val);
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = val;
      do @(posedge clock); while (!csr_ready);
      write_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic load_settings(bit [15:0] v[8]);
      wait_drained();
      for (int k = 0; k < 8; k++) csr_write(k[3:0], v[k]);
   endtask

   // sync traffic around a drifting true offset, with noise, bursts and malformed messages
   task automatic run_traffic(int count);
      bit [63:0] t, echo, arrival, remote, rtt;
      longint    true_off, off;
      int        burst, pick;
      t = 64'd1 << 40;
      true_off = longint'($urandom_range(0, 2_000_000_000)) - 1_000_000_000;
      burst = 0;
      for (int k = 0; k < count; k++) begin
         t += $urandom_range(1, 1 << 28);
         true_off += longint'($urandom_range(0, 2000)) - 1000;
         pick = $urandom_range(99);
         if (burst == 0 && pick < 2) burst = 12;
         if (pick >= 92 && burst == 0) begin
            send_sync(0, {$urandom, $urandom}, {$urandom, $urandom});
         end else if (pick >= 88 && burst == 0) begin
            send_sync({1'b1, 31'($urandom), 32'($urandom)}, {$urandom, $urandom},
                      {$urandom, $urandom});
         end else if (pick >= 85 && burst == 0) begin
            send_sync({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            echo = t;
            if (burst > 0) begin
               rtt = 64'd70_000_000 + $urandom_range(0, 1 << 30);
               burst--;
            end else rtt = $urandom_range(0, 12_000_000);
            off = true_off + longint'($urandom_range(0, 2_000_000)) - 1_000_000;
            if ($urandom_range(99) < 6) off += 40_000_000;
            arrival = echo + rtt;
            remote = echo + (rtt >> 1) - off;
            send_sync(remote, echo, arrival);
         end
      end
   endtask

   function automatic bit field_ok(string name, bit [63:0] e, bit [63:0] g);
      if (e == g) return 1;
      if (errors < 10) $display("mismatch %s: expected %h got %h", name, e, g);
      return 0;
   endfunction

   // response checking
   always @(posedge clock) begin
      sync_result_type e, g;
      bit ok;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g.rr = rsp_tdata[63:0];
         g.re = rsp_tdata[127:64];
         g.obs = rsp_tdata[191:128];
         g.est = rsp_tdata[255:192];
         g.rtt = rsp_tdata[319:256];
         g.st = rsp_tdata[321:320];
         g.warn = rsp_tdata[322];
         g.shared = rsp_tdata[386:323];
         g.conv = rsp_tdata[387];
         g.rv = rsp_tuser[0];
         g.ov = rsp_tuser[1];
         if (pending_results.size() == 0) begin
            if (errors < 10) $display("response word with nothing expected");
            errors++;
         end else begin
            e = pending_results.pop_front();
            ok = 1;
            ok &= field_ok("reply_valid", e.rv, g.rv);
            ok &= field_ok("reply_remote_stamp", e.rr, g.rr);
            ok &= field_ok("reply_echo_stamp", e.re, g.re);
            ok &= field_ok("observation_valid", e.ov, g.ov);
            ok &= field_ok("observed_offset", e.obs, g.obs);
            ok &= field_ok("estimated_offset", e.est, g.est);
            ok &= field_ok("round_trip_ns", e.rtt, g.rtt);
            ok &= field_ok("sample_status", e.st, g.st);
            ok &= field_ok("rtt_warning", e.warn, g.warn);
            ok &= field_ok("shared_offset", e.shared, g.shared);
            ok &= field_ok("converged", e.conv, g.conv);
            if (!ok) errors++;
         end
      end
   end

   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         rsp_tready = quiet || ($urandom_range(99) >= 6);
      end
   end

   initial begin
      sync_row_type rows[12];
      bit [15:0] cfg[8];
      errors = 0;
      quiet = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      alpha_start = 3277; beta_start = 3277; alpha_end = 197; beta_end = 197;
      settle_samples = 500; rtt_limit_ms = 10; dev_limit_ms = 10; outlier_limit = 10;
      clear_filter();
      rows = '{
         '{64'd0, '1, '1, 1, 1},
         '{64'd0, 64'd0, 64'd0, 1, 1},
         '{INT_MIN, '1, '1, 1, 0},
         '{'1, {16{4'h5}}, {16{4'hA}}, 1, 0},
         '{64'd1000, 64'd100, 64'd2100, 0, 0},
         '{INT_MAX, 64'd0, 64'd0, 0, 0},
         '{64'd7, 64'd5, 64'd4, 0, 0},
         '{64'd3, 64'd0, 64'd1, 0, 0},
         '{64'd1, '1, '1, 0, 0},
         '{64'd1000, 64'd0, 64'd1000, 0, 0},
         '{64'd1, 64'd1 << 62, 64'd1 << 62, 0, 0},
         '{64'd0, 64'd123, 64'd456, 0, 0}
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (rows[k])
         send_sync(rows[k].remote, rows[k].echo, rows[k].arrival, rows[k].typed, rows[k].rv);
      run_traffic(PHASE_ITEMS - 12);

      cfg = '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd10, 16'd10, 16'd0};
      load_settings(cfg);
      run_traffic(PHASE_ITEMS);

      cfg = '{16'd3277, 16'd3277, 16'd197, 16'd197, 16'd40, 16'd20, 16'd5, 16'd3};
      load_settings(cfg);
      run_traffic(PHASE_ITEMS);

      cfg = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd255};
      load_settings(cfg);
      quiet = 1;
      run_traffic(PHASE_ITEMS);
      quiet = 0;

      cfg = '{16'd20000, 16'd8000, 16'd1000, 16'd300, 16'd0, 16'd0, 16'd0, 16'd1};
      load_settings(cfg);
      run_traffic(PHASE_ITEMS / 2);

      cfg = '{16'd5000, 16'd2000, 16'd500, 16'd100, 16'd20, 16'd12, 16'd2, 16'd5};
      load_settings(cfg);
      run_traffic(PHASE_ITEMS);

      wait_drained();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
